// ===== src/bpa_pkg.sv =====
`timescale 1ns / 1ps

package bpa_pkg;

   // Width of the CSR write data on the port, and width of a wanted order.
   localparam int CSR_W  = 13;
   localparam int WANT_W = 5;

   typedef struct packed {
      logic [1:0]  mode;
      logic [15:0] request_pages;
      logic [11:0] page_index;
      logic [12:0] end_index;
   } bpa_req_type;

   typedef struct packed {
      logic        status;
      logic [11:0] block_index;
   } bpa_rsp_type;

   typedef enum logic [1:0] {
      MODE_ALLOC   = 2'd0,
      MODE_FREE    = 2'd1,
      MODE_RESERVE = 2'd2,
      MODE_BUILD   = 2'd3
   } bpa_mode_type;

   // Write enables of the page memory, one per field of an entry.
   typedef struct packed {
      logic order;
      logic taken;
      logic next;
      logic prev;
   } bpa_wen_type;

   typedef enum logic [4:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DISPATCH,
      ST_ALLOC_SCAN,
      ST_ALLOC_SPLIT,
      ST_ALLOC_FIN,
      ST_FREE_CAP,
      ST_FREE_BUD,
      ST_FREE_BUDR,
      ST_FREE_M1,
      ST_FREE_M2,
      ST_RSV,
      ST_BLD_INIT,
      ST_BLD_PAIR,
      ST_BLD_PAIR_A,
      ST_BLD_PAIR_B,
      ST_BLD_WALK,
      ST_BLD_LINK,
      ST_BLD_TAIL,
      ST_UNL_RD,
      ST_UNL_CAP,
      ST_UNL_NEXT,
      ST_PUSH_A,
      ST_PUSH_B,
      ST_DONE
   } bpa_state_type;

   // Smallest order whose block holds the requested pages.
   function automatic logic [WANT_W-1:0] bpa_want(input logic [15:0] pages);
      logic [15:0]       m;
      logic [WANT_W-1:0] w;
      m = pages - 16'd1;
      w = '0;
      for (int i = 0; i < 16; i++) begin
         if (m[i]) begin
            w = WANT_W'(i + 1);
         end
      end
      return w;
   endfunction

endpackage

// ===== src/buddy_page_allocator.sv =====
`timescale 1ns / 1ps

// Buddy page allocator over page indices.
// Input items arrive on req_valid / req_stall / req_data and carry a mode:
// alloc, free, reserve a page range, or build the free lists. Every item
// gives exactly one result item on rsp_valid / rsp_stall / rsp_data, with a
// status bit and, for a successful alloc, the first page of the block.
// The page count register is written through csr_wen / csr_wdata; the user
// must write it only while the block is idle, which the block does not
// enforce; values above NUM_PAGES saturate. One item is worked on at a
// time. All per-page state sits in one memory with a single access per
// cycle. Alloc scans the orders up from the wanted one and splits the
// block found down to it; free merges the block with its free buddy order
// by order; reserve marks each page of the range taken; build merges free
// buddy pairs on each order, then walks the blocks into the free lists.
// After reset a clearing pass writes every page entry with req_stall high;
// the free lists start empty. The result sits in an output register, so
// the next item is accepted while rsp_stall holds the previous result;
// that item waits at its end until the output register frees.
module buddy_page_allocator #(
   parameter int NUM_PAGES  = 4096,
   parameter int NUM_ORDERS = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  bpa_pkg::bpa_req_type         req_data,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output bpa_pkg::bpa_rsp_type         rsp_data,
   input  logic                         csr_wen,
   input  logic [bpa_pkg::CSR_W-1:0]    csr_wdata
);
   import bpa_pkg::*;

   localparam int PW  = $clog2(NUM_PAGES);
   localparam int LW  = $clog2(NUM_PAGES + 1);
   localparam int OW  = $clog2(NUM_ORDERS);
   localparam int CFW = ((LW > CSR_W) ? LW : CSR_W) + 1;
   localparam logic [LW-1:0] PC_RESET = LW'((NUM_PAGES < 4096) ? NUM_PAGES : 4096);

   logic [LW-1:0] page_count_ff, page_count_in;
   logic          rsp_valid_ff, rsp_valid_in;
   bpa_rsp_type   rsp_data_ff, rsp_data_in;

   logic          seq_ready, seq_start, seq_done, out_free;
   bpa_rsp_type   seq_result;

   bpa_wen_type   mem_wen;
   logic [PW-1:0] mem_wr_addr, mem_rd_addr;
   logic [OW-1:0] mem_wr_order, mem_order;
   logic          mem_wr_taken, mem_taken, mem_rd_en;
   logic [LW-1:0] mem_wr_next, mem_wr_prev, mem_next, mem_prev;

   // Page count register, saturated at the number of pages in the memory.
   always_comb begin
      page_count_in = page_count_ff;
      if (csr_wen) begin
         if (CFW'(csr_wdata) > CFW'(NUM_PAGES)) begin
            page_count_in = LW'(NUM_PAGES);
         end else begin
            page_count_in = LW'(csr_wdata);
         end
      end
   end

   // The output register frees when it is empty or its item is taken.
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign seq_start = req_valid && seq_ready;
   assign req_stall = !seq_ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (seq_done) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = seq_result;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         page_count_ff <= PC_RESET;
         rsp_valid_ff  <= 1'b0;
      end else begin
         page_count_ff <= page_count_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   bpa_seq #(
      .NUM_PAGES  (NUM_PAGES),
      .NUM_ORDERS (NUM_ORDERS)
   ) u_seq (
      .clock        (clock),
      .reset        (reset),
      .page_count   (page_count_ff),
      .start        (seq_start),
      .req          (req_data),
      .ready        (seq_ready),
      .out_free     (out_free),
      .done         (seq_done),
      .result       (seq_result),
      .mem_wen      (mem_wen),
      .mem_wr_addr  (mem_wr_addr),
      .mem_wr_order (mem_wr_order),
      .mem_wr_taken (mem_wr_taken),
      .mem_wr_next  (mem_wr_next),
      .mem_wr_prev  (mem_wr_prev),
      .mem_rd_en    (mem_rd_en),
      .mem_rd_addr  (mem_rd_addr),
      .mem_order    (mem_order),
      .mem_taken    (mem_taken),
      .mem_next     (mem_next),
      .mem_prev     (mem_prev)
   );

   bpa_page_mem #(
      .NUM_PAGES  (NUM_PAGES),
      .NUM_ORDERS (NUM_ORDERS)
   ) u_mem (
      .clock    (clock),
      .wr_en    (mem_wen),
      .wr_addr  (mem_wr_addr),
      .wr_order (mem_wr_order),
      .wr_taken (mem_wr_taken),
      .wr_next  (mem_wr_next),
      .wr_prev  (mem_wr_prev),
      .rd_en    (mem_rd_en),
      .rd_addr  (mem_rd_addr),
      .rd_order (mem_order),
      .rd_taken (mem_taken),
      .rd_next  (mem_next),
      .rd_prev  (mem_prev)
   );

endmodule

// ===== src/bpa_page_mem.sv =====
`timescale 1ns / 1ps

module bpa_page_mem #(
   parameter int NUM_PAGES  = 4096,
   parameter int NUM_ORDERS = 16
) (
   input  logic                              clock,
   input  bpa_pkg::bpa_wen_type              wr_en,
   input  logic [$clog2(NUM_PAGES)-1:0]      wr_addr,
   input  logic [$clog2(NUM_ORDERS)-1:0]     wr_order,
   input  logic                              wr_taken,
   input  logic [$clog2(NUM_PAGES+1)-1:0]    wr_next,
   input  logic [$clog2(NUM_PAGES+1)-1:0]    wr_prev,
   input  logic                              rd_en,
   input  logic [$clog2(NUM_PAGES)-1:0]      rd_addr,
   output logic [$clog2(NUM_ORDERS)-1:0]     rd_order,
   output logic                              rd_taken,
   output logic [$clog2(NUM_PAGES+1)-1:0]    rd_next,
   output logic [$clog2(NUM_PAGES+1)-1:0]    rd_prev
);
   import bpa_pkg::*;

   localparam int OW = $clog2(NUM_ORDERS);
   localparam int LW = $clog2(NUM_PAGES + 1);

   logic [OW-1:0] order_mem [NUM_PAGES];
   logic          taken_mem [NUM_PAGES];
   logic [LW-1:0] next_mem  [NUM_PAGES];
   logic [LW-1:0] prev_mem  [NUM_PAGES];

   logic [OW-1:0] rd_order_ff;
   logic          rd_taken_ff;
   logic [LW-1:0] rd_next_ff;
   logic [LW-1:0] rd_prev_ff;

   // One entry, with a write enable for each field.
   always_ff @(posedge clock) begin
      if (wr_en.order) begin
         order_mem[wr_addr] <= wr_order;
      end
      if (wr_en.taken) begin
         taken_mem[wr_addr] <= wr_taken;
      end
      if (wr_en.next) begin
         next_mem[wr_addr] <= wr_next;
      end
      if (wr_en.prev) begin
         prev_mem[wr_addr] <= wr_prev;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_order_ff <= order_mem[rd_addr];
         rd_taken_ff <= taken_mem[rd_addr];
         rd_next_ff  <= next_mem[rd_addr];
         rd_prev_ff  <= prev_mem[rd_addr];
      end
   end

   assign rd_order = rd_order_ff;
   assign rd_taken = rd_taken_ff;
   assign rd_next  = rd_next_ff;
   assign rd_prev  = rd_prev_ff;

endmodule

// ===== src/bpa_seq.sv =====
`timescale 1ns / 1ps

module bpa_seq #(
   parameter int NUM_PAGES  = 4096,
   parameter int NUM_ORDERS = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic [$clog2(NUM_PAGES+1)-1:0]    page_count,
   input  logic                              start,
   input  bpa_pkg::bpa_req_type              req,
   output logic                              ready,
   input  logic                              out_free,
   output logic                              done,
   output bpa_pkg::bpa_rsp_type              result,
   output bpa_pkg::bpa_wen_type              mem_wen,
   output logic [$clog2(NUM_PAGES)-1:0]      mem_wr_addr,
   output logic [$clog2(NUM_ORDERS)-1:0]     mem_wr_order,
   output logic                              mem_wr_taken,
   output logic [$clog2(NUM_PAGES+1)-1:0]    mem_wr_next,
   output logic [$clog2(NUM_PAGES+1)-1:0]    mem_wr_prev,
   output logic                              mem_rd_en,
   output logic [$clog2(NUM_PAGES)-1:0]      mem_rd_addr,
   input  logic [$clog2(NUM_ORDERS)-1:0]     mem_order,
   input  logic                              mem_taken,
   input  logic [$clog2(NUM_PAGES+1)-1:0]    mem_next,
   input  logic [$clog2(NUM_PAGES+1)-1:0]    mem_prev
);
   import bpa_pkg::*;

   localparam int PW  = $clog2(NUM_PAGES);
   localparam int LW  = $clog2(NUM_PAGES + 1);
   localparam int OW  = $clog2(NUM_ORDERS);
   localparam int OCW = $clog2(NUM_ORDERS + 1);
   localparam int MW  = (LW > NUM_ORDERS) ? LW : NUM_ORDERS;
   localparam int CW  = ((MW > CSR_W) ? MW : CSR_W) + 2;
   localparam logic [LW-1:0] NONE = LW'(NUM_PAGES);

   bpa_state_type state_ff, state_in, ret_ff, ret_in;
   bpa_mode_type  mode_ff, mode_in;
   logic [WANT_W-1:0] want_ff, want_in;
   logic          bad_ff, bad_in;
   logic [OCW-1:0] ord_ff, ord_in, aord_ff, aord_in;
   logic [PW-1:0] pg_ff, pg_in, clr_ff, clr_in;
   logic [CW-1:0] idx_ff, idx_in, bud_ff, bud_in, end_ff, end_in;
   logic [LW-1:0] nsave_ff, nsave_in, psave_ff, psave_in, hsave_ff, hsave_in;
   logic [OW-1:0] border_ff, border_in;
   logic          amatch_ff, amatch_in;
   logic          status_ff, status_in;
   logic [11:0]   blk_ff, blk_in;

   logic [LW-1:0] head_ff [NUM_ORDERS];
   logic [LW-1:0] tail_ff [NUM_ORDERS];
   logic          head_we, head_clr, tail_we, tail_clr;
   logic [OW-1:0] head_waddr, head_raddr, tail_waddr, tail_raddr;
   logic [LW-1:0] head_wdata, tail_wdata, head_rd, tail_rd;
   logic          head_ok, tail_ok;

   logic [CW-1:0] pc_w, ord_one, ord_two, bud_w, dec_one, split_bud, link_one, bord_one;
   logic [CW-1:0] pair_next;
   logic [OCW-1:0] dec_ord;
   logic          want_hit, last_ord, last_pair, alloc_bad, pair_hit, bud_merge;

   assign pc_w      = CW'(page_count);
   assign ord_one   = CW'(1) << ord_ff;
   assign ord_two   = CW'(1) << (ord_ff + OCW'(1));
   assign bud_w     = idx_ff ^ ord_one;
   assign dec_ord   = ord_ff - OCW'(1);
   assign dec_one   = CW'(1) << dec_ord;
   assign split_bud = idx_ff ^ dec_one;
   assign link_one  = CW'(1) << mem_order;
   assign bord_one  = CW'(1) << border_ff;
   assign pair_next = idx_ff + ord_two;
   assign want_hit  = (ord_ff == OCW'(want_ff));
   assign last_ord  = (ord_ff + OCW'(1)) >= OCW'(NUM_ORDERS);
   assign last_pair = (ord_ff + OCW'(2)) >= OCW'(NUM_ORDERS);
   assign alloc_bad = bad_ff || (want_ff >= WANT_W'(NUM_ORDERS));
   assign pair_hit  = amatch_ff && !mem_taken && (OCW'(mem_order) == ord_ff);
   assign bud_merge = !mem_taken && (OCW'(mem_order) == ord_ff);

   assign head_raddr = (state_ff == ST_ALLOC_SCAN) ? ord_ff[OW-1:0] : aord_ff[OW-1:0];
   assign head_rd    = head_ff[head_raddr];
   assign head_ok    = head_rd < NONE;
   assign tail_raddr = (state_ff == ST_BLD_LINK) ? mem_order : border_ff;
   assign tail_rd    = tail_ff[tail_raddr];
   assign tail_ok    = tail_rd < NONE;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff   <= '0;
         for (int i = 0; i < NUM_ORDERS; i++) begin
            head_ff[i] <= NONE;
         end
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         if (head_clr) begin
            for (int i = 0; i < NUM_ORDERS; i++) begin
               head_ff[i] <= NONE;
            end
         end else if (head_we) begin
            head_ff[head_waddr] <= head_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      ret_ff    <= ret_in;
      mode_ff   <= mode_in;
      want_ff   <= want_in;
      bad_ff    <= bad_in;
      ord_ff    <= ord_in;
      aord_ff   <= aord_in;
      pg_ff     <= pg_in;
      idx_ff    <= idx_in;
      bud_ff    <= bud_in;
      end_ff    <= end_in;
      nsave_ff  <= nsave_in;
      psave_ff  <= psave_in;
      hsave_ff  <= hsave_in;
      border_ff <= border_in;
      amatch_ff <= amatch_in;
      status_ff <= status_in;
      blk_ff    <= blk_in;
      if (tail_clr) begin
         for (int i = 0; i < NUM_ORDERS; i++) begin
            tail_ff[i] <= NONE;
         end
      end else if (tail_we) begin
         tail_ff[tail_waddr] <= tail_wdata;
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (clr_ff == PW'(NUM_PAGES - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (start) begin
               state_in = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            unique case (mode_ff)
               MODE_ALLOC:   state_in = alloc_bad ? ST_DONE : ST_ALLOC_SCAN;
               MODE_FREE:    state_in = (idx_ff < pc_w) ? ST_FREE_CAP : ST_DONE;
               MODE_RESERVE: state_in = ST_RSV;
               MODE_BUILD:   state_in = ST_BLD_INIT;
               default:      state_in = ST_DONE;
            endcase
         end
         ST_ALLOC_SCAN: begin
            if (head_ok) begin
               state_in = ST_UNL_RD;
            end else if (last_ord) begin
               state_in = ST_DONE;
            end
         end
         ST_ALLOC_SPLIT: begin
            if (want_hit) begin
               state_in = ST_ALLOC_FIN;
            end else if (split_bud < pc_w) begin
               state_in = ST_PUSH_A;
            end
         end
         ST_ALLOC_FIN: state_in = ST_DONE;
         ST_FREE_CAP:  state_in = mem_taken ? ST_PUSH_A : ST_DONE;
         ST_FREE_BUD: begin
            state_in = (!last_ord && (bud_w < pc_w)) ? ST_FREE_BUDR : ST_DONE;
         end
         ST_FREE_BUDR: state_in = bud_merge ? ST_UNL_RD : ST_DONE;
         ST_FREE_M1:   state_in = ST_UNL_RD;
         ST_FREE_M2:   state_in = ST_PUSH_A;
         ST_RSV: begin
            if (idx_ff >= end_ff) begin
               state_in = ST_DONE;
            end
         end
         ST_BLD_INIT: state_in = ST_BLD_PAIR;
         ST_BLD_PAIR: begin
            if (bud_w < pc_w) begin
               state_in = ST_BLD_PAIR_A;
            end else if (last_pair) begin
               state_in = ST_BLD_WALK;
            end
         end
         ST_BLD_PAIR_A: state_in = ST_BLD_PAIR_B;
         ST_BLD_PAIR_B: begin
            if (pair_next < pc_w) begin
               state_in = ST_BLD_PAIR;
            end else begin
               state_in = last_pair ? ST_BLD_WALK : ST_BLD_PAIR;
            end
         end
         ST_BLD_WALK: state_in = (idx_ff < pc_w) ? ST_BLD_LINK : ST_DONE;
         ST_BLD_LINK: state_in = mem_taken ? ST_BLD_WALK : ST_BLD_TAIL;
         ST_BLD_TAIL: state_in = ST_BLD_WALK;
         ST_UNL_RD:   state_in = ST_UNL_CAP;
         ST_UNL_CAP:  state_in = ST_UNL_NEXT;
         ST_UNL_NEXT: state_in = ret_ff;
         ST_PUSH_A:   state_in = ST_PUSH_B;
         ST_PUSH_B:   state_in = ret_ff;
         ST_DONE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Outputs and datapath.
   always_comb begin
      ret_in       = ret_ff;
      mode_in      = mode_ff;
      want_in      = want_ff;
      bad_in       = bad_ff;
      ord_in       = ord_ff;
      aord_in      = aord_ff;
      pg_in        = pg_ff;
      idx_in       = idx_ff;
      bud_in       = bud_ff;
      end_in       = end_ff;
      nsave_in     = nsave_ff;
      psave_in     = psave_ff;
      hsave_in     = hsave_ff;
      border_in    = border_ff;
      amatch_in    = amatch_ff;
      status_in    = status_ff;
      blk_in       = blk_ff;
      clr_in       = clr_ff;
      mem_wen      = '0;
      mem_wr_addr  = pg_ff;
      mem_wr_order = OW'(aord_ff);
      mem_wr_taken = 1'b0;
      mem_wr_next  = NONE;
      mem_wr_prev  = NONE;
      mem_rd_en    = 1'b0;
      mem_rd_addr  = idx_ff[PW-1:0];
      head_we      = 1'b0;
      head_clr     = 1'b0;
      head_waddr   = aord_ff[OW-1:0];
      head_wdata   = NONE;
      tail_we      = 1'b0;
      tail_clr     = 1'b0;
      tail_waddr   = border_ff;
      tail_wdata   = LW'(idx_ff);
      done         = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            mem_wen      = '1;
            mem_wr_addr  = clr_ff;
            mem_wr_order = '0;
            clr_in       = clr_ff + PW'(1);
         end
         ST_IDLE: begin
            if (start) begin
               mode_in = bpa_mode_type'(req.mode);
               want_in = bpa_want(req.request_pages);
               bad_in  = (req.request_pages == 16'd0);
               idx_in  = CW'(req.page_index);
               end_in  = (CW'(req.end_index) > pc_w) ? pc_w : CW'(req.end_index);
            end
         end
         ST_DISPATCH: begin
            status_in = 1'b0;
            blk_in    = '0;
            unique case (mode_ff)
               MODE_ALLOC: begin
                  status_in = alloc_bad;
                  ord_in    = OCW'(want_ff);
               end
               MODE_FREE: begin
                  status_in = !(idx_ff < pc_w);
                  mem_rd_en = 1'b1;
               end
               default: begin
               end
            endcase
         end
         ST_ALLOC_SCAN: begin
            if (head_ok) begin
               pg_in   = head_rd[PW-1:0];
               aord_in = ord_ff;
               idx_in  = CW'(head_rd);
               ret_in  = ST_ALLOC_SPLIT;
            end else if (last_ord) begin
               status_in = 1'b1;
            end else begin
               ord_in = ord_ff + OCW'(1);
            end
         end
         ST_ALLOC_SPLIT: begin
            if (!want_hit) begin
               ord_in  = dec_ord;
               pg_in   = split_bud[PW-1:0];
               aord_in = dec_ord;
               ret_in  = ST_ALLOC_SPLIT;
            end
         end
         ST_ALLOC_FIN: begin
            mem_wen.order = 1'b1;
            mem_wen.taken = 1'b1;
            mem_wr_addr   = idx_ff[PW-1:0];
            mem_wr_order  = OW'(want_ff);
            mem_wr_taken  = 1'b1;
            blk_in        = 12'(idx_ff);
         end
         ST_FREE_CAP: begin
            if (mem_taken) begin
               ord_in  = OCW'(mem_order);
               aord_in = OCW'(mem_order);
               pg_in   = idx_ff[PW-1:0];
               ret_in  = ST_FREE_BUD;
            end else begin
               status_in = 1'b1;
            end
         end
         ST_FREE_BUD: begin
            bud_in      = bud_w;
            mem_rd_en   = 1'b1;
            mem_rd_addr = bud_w[PW-1:0];
         end
         ST_FREE_BUDR: begin
            pg_in   = idx_ff[PW-1:0];
            aord_in = ord_ff;
            ret_in  = ST_FREE_M1;
         end
         ST_FREE_M1: begin
            pg_in  = bud_ff[PW-1:0];
            ret_in = ST_FREE_M2;
         end
         ST_FREE_M2: begin
            ord_in  = ord_ff + OCW'(1);
            aord_in = ord_ff + OCW'(1);
            idx_in  = idx_ff & bud_ff;
            pg_in   = PW'(idx_ff & bud_ff);
            ret_in  = ST_FREE_BUD;
         end
         ST_RSV: begin
            if (idx_ff < end_ff) begin
               mem_wen.taken = 1'b1;
               mem_wr_addr   = idx_ff[PW-1:0];
               mem_wr_taken  = 1'b1;
               idx_in        = idx_ff + CW'(1);
            end
         end
         ST_BLD_INIT: begin
            head_clr = 1'b1;
            tail_clr = 1'b1;
            ord_in   = '0;
            idx_in   = '0;
         end
         ST_BLD_PAIR: begin
            if (bud_w < pc_w) begin
               mem_rd_en = 1'b1;
            end else begin
               idx_in = '0;
               if (!last_pair) begin
                  ord_in = ord_ff + OCW'(1);
               end
            end
         end
         ST_BLD_PAIR_A: begin
            amatch_in   = !mem_taken && (OCW'(mem_order) == ord_ff);
            mem_rd_en   = 1'b1;
            mem_rd_addr = bud_w[PW-1:0];
         end
         ST_BLD_PAIR_B: begin
            if (pair_hit) begin
               mem_wen.order = 1'b1;
               mem_wr_addr   = idx_ff[PW-1:0];
               mem_wr_order  = OW'(ord_ff + OCW'(1));
            end
            if (pair_next < pc_w) begin
               idx_in = pair_next;
            end else begin
               idx_in = '0;
               if (!last_pair) begin
                  ord_in = ord_ff + OCW'(1);
               end
            end
         end
         ST_BLD_WALK: begin
            mem_rd_en = 1'b1;
         end
         ST_BLD_LINK: begin
            border_in = mem_order;
            if (mem_taken) begin
               idx_in = idx_ff + link_one;
            end else begin
               mem_wen.next = 1'b1;
               mem_wen.prev = 1'b1;
               mem_wr_addr  = idx_ff[PW-1:0];
               mem_wr_next  = NONE;
               mem_wr_prev  = tail_rd;
            end
         end
         ST_BLD_TAIL: begin
            if (tail_ok) begin
               mem_wen.next = 1'b1;
               mem_wr_addr  = tail_rd[PW-1:0];
               mem_wr_next  = LW'(idx_ff);
            end else begin
               head_we    = 1'b1;
               head_waddr = border_ff;
               head_wdata = LW'(idx_ff);
            end
            tail_we = 1'b1;
            idx_in  = idx_ff + bord_one;
         end
         ST_UNL_RD: begin
            mem_rd_en   = 1'b1;
            mem_rd_addr = pg_ff;
         end
         ST_UNL_CAP: begin
            nsave_in = mem_next;
            psave_in = mem_prev;
            if (mem_prev < NONE) begin
               mem_wen.next = 1'b1;
               mem_wr_addr  = mem_prev[PW-1:0];
               mem_wr_next  = mem_next;
            end else begin
               head_we    = 1'b1;
               head_wdata = (mem_next < NONE) ? mem_next : NONE;
            end
         end
         ST_UNL_NEXT: begin
            if (nsave_ff < NONE) begin
               mem_wen.prev = 1'b1;
               mem_wr_addr  = nsave_ff[PW-1:0];
               mem_wr_prev  = (psave_ff < NONE) ? psave_ff : NONE;
            end
         end
         ST_PUSH_A: begin
            // The pushed page becomes a free block head of this order.
            mem_wen      = '1;
            mem_wr_order = OW'(aord_ff);
            mem_wr_taken = 1'b0;
            mem_wr_next  = head_rd;
            mem_wr_prev  = NONE;
            hsave_in     = head_rd;
         end
         ST_PUSH_B: begin
            if (hsave_ff < NONE) begin
               mem_wen.prev = 1'b1;
               mem_wr_addr  = hsave_ff[PW-1:0];
               mem_wr_prev  = LW'(pg_ff);
            end
            head_we    = 1'b1;
            head_wdata = LW'(pg_ff);
         end
         ST_DONE: begin
            done = out_free;
         end
         default: begin
         end
      endcase
   end

   assign ready              = (state_ff == ST_IDLE);
   assign result.status      = status_ff;
   assign result.block_index = blk_ff;

endmodule

// ===== src/bpa_checker.sv =====
`timescale 1ns / 1ps

module bpa_checker (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_stall,
   input logic                  rsp_valid,
   input logic                  rsp_stall,
   input bpa_pkg::bpa_rsp_type  rsp_data
);
   import bpa_pkg::*;

   // The clearing pass keeps the input closed right after reset.
   a_clear_after_reset: assert property (@(posedge clock) reset |=> req_stall)
      else $error("input open right after reset");

   // One item at a time: an accepted item closes the input.
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("input still open after an item was accepted");

   // A failed result never carries a block index.
   a_fail_index: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status |-> rsp_data.block_index == 12'd0)
      else $error("failed result with nonzero block index");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");

endmodule

bind buddy_page_allocator bpa_checker u_bpa_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
